FILE: rtl/core/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned HEAP_UNITS_DEF = 4096;

  localparam int unsigned NXT_W     = 16;  // link field, wide enough for the largest store
  localparam int unsigned SZ_W      = 17;  // header sizes wrap modulo 2^17
  localparam int unsigned CNT_W     = 17;  // running free count
  localparam int unsigned CUR_W     = 18;  // unit index plus a split remainder
  localparam int unsigned UNITS_W   = 13;
  localparam int unsigned NEED_W    = 21;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_ALLOC    = 2'd0,
    STAT_REFUSED  = 2'd1,
    STAT_RELEASED = 2'd2,
    STAT_IGNORED  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_BASE  = 2'd0,
    REG_HEAP_BYTES = 2'd1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_AWALK,
    S_ATAIL,
    S_RCHK,
    S_RINS,
    S_RHEAD,
    S_RWALK,
    S_RLAST,
    S_RMERGE,
    S_RNB,
    S_RFIX,
    S_RESP
  } state_e;

  typedef struct packed {
    logic             command;
    logic [23:0]      request_bytes;
    logic [31:0]      release_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      block_address;
    logic [12:0]      free_units;
  } out_item_t;

  typedef struct packed {
    logic             ln;
    logic [NXT_W-1:0] nx;
    logic [SZ_W-1:0]  sz;
  } hdr_t;

  typedef struct packed {
    logic             restart;
    logic [31:0]      heap_base;
    logic [16:0]      heap_bytes;
  } cfg_t;

  // an unlinked header always carries a zero link
  function automatic hdr_t mk_hdr(logic ln, logic [NXT_W-1:0] nx, logic [SZ_W-1:0] sz);
    hdr_t h;
    h.ln = ln;
    h.nx = ln ? nx : '0;
    h.sz = sz;
    return h;
  endfunction

endpackage

FILE: rtl/core/ffa_hdr_mem.sv
// ----------------------------------------------------------------------------
// ffa_hdr_mem
// Unit header store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffa_hdr_mem
  import ffa_pkg::*;
#(
  parameter int unsigned DEPTH = HEAP_UNITS_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  hdr_t          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output hdr_t          rdata_o
);

  hdr_t mem [DEPTH];
  hdr_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for allocate and release: walks the free list one header a cycle,
// rewrites headers, keeps head and free count, holds the result register.
// ----------------------------------------------------------------------------
module ffa_ctrl
  import ffa_pkg::*;
#(
  parameter int unsigned HEAP_UNITS = HEAP_UNITS_DEF,
  localparam int unsigned IW = $clog2(HEAP_UNITS),
  localparam int unsigned KW = $clog2(HEAP_UNITS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  in_item_t      in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output out_item_t     out_item_o,
  output logic          we_o,
  output logic [IW-1:0] waddr_o,
  output hdr_t          wdata_o,
  output logic [IW-1:0] raddr_o,
  input  hdr_t          rdata_i
);

  localparam logic [CUR_W-1:0] HU_C   = CUR_W'(HEAP_UNITS);
  localparam logic [KW-1:0]    K_LAST = KW'(HEAP_UNITS);
  localparam logic [IW-1:0]    C_LAST = IW'(HEAP_UNITS - 1);

  state_e              state_q, state_d;
  logic [IW-1:0]       clr_q, clr_d;
  logic [NEED_W-1:0]   need_q, need_d;
  logic [31:0]         addr_q, addr_d;
  logic [CUR_W-1:0]    cur_q, cur_d;
  logic [IW-1:0]       prev_q, prev_d;
  logic [SZ_W-1:0]     prev_sz_q, prev_sz_d;
  logic [KW-1:0]       k_q, k_d;
  logic [IW-1:0]       head_q, head_d;
  logic                head_ok_q, head_ok_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IW-1:0]       ins_q, ins_d;
  hdr_t                ins_hdr_q, ins_hdr_d;
  hdr_t                cur_hdr_q, cur_hdr_d;
  status_e             stat_q, stat_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q, out_item_d;

  // heap size in units, clamped to the store
  logic [16:0]         units17, units_c;
  logic [UNITS_W-1:0]  units;
  assign units17 = {4'b0, cfg_i.heap_bytes[16:4]};
  assign units_c = (units17 > 17'(HEAP_UNITS)) ? 17'(HEAP_UNITS) : units17;
  assign units   = units_c[UNITS_W-1:0];

  logic              in_xfer, out_free, k_max;
  logic [24:0]       nb_round;
  logic [NEED_W-1:0] need_in;
  assign in_xfer  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;
  assign k_max    = (k_q == K_LAST);
  assign nb_round = {1'b0, in_item_i.request_bytes} + 25'd15;
  assign need_in  = NEED_W'(nb_round[24:4]) + NEED_W'(1);

  // allocation walk
  logic             fit, exact, hit_head, tail_ok;
  logic [SZ_W-1:0]  rest;
  logic [CUR_W-1:0] tail;
  assign fit      = NEED_W'(rdata_i.sz) >= need_q;
  assign exact    = NEED_W'(rdata_i.sz) == need_q;
  assign hit_head = cur_q == CUR_W'(head_q);
  assign rest     = rdata_i.sz - need_q[SZ_W-1:0];
  assign tail     = cur_q + CUR_W'(rest);
  assign tail_ok  = tail < HU_C;

  // release checks
  logic [31:0] off;
  logic [27:0] ins_w;
  logic        rel_ign;
  assign off     = addr_q - cfg_i.heap_base;
  assign ins_w   = off[31:4] - 28'd1;
  assign rel_ign = (addr_q == 32'd0) || (addr_q < cfg_i.heap_base) ||
                   (off >= {15'b0, cfg_i.heap_bytes}) || (off[31:4] == 28'd0) ||
                   (ins_w >= 28'(units));

  // release walk and merges
  logic [SZ_W-1:0] ins_sz;
  logic            r_adv, head_touch, nb_merge, cur_touch;
  hdr_t            ce;
  assign ins_sz     = ins_hdr_q.sz;
  assign r_adv      = rdata_i.ln && (rdata_i.nx < NXT_W'(ins_q));
  assign head_touch = (CUR_W'(ins_q) + CUR_W'(ins_sz)) == CUR_W'(head_q);
  assign nb_merge   = cur_hdr_q.ln &&
                      ((CUR_W'(ins_q) + CUR_W'(ins_sz)) == CUR_W'(cur_hdr_q.nx));
  // a release onto the extent the walk stopped at sees its fresh header
  assign ce         = (cur_q == CUR_W'(ins_q)) ? ins_hdr_q : cur_hdr_q;
  assign cur_touch  = (cur_q + CUR_W'(ce.sz)) == CUR_W'(ins_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (clr_q == C_LAST) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.command == CMD_RELEASE) begin
            state_d = S_RCHK;
          end else if (!head_ok_q || (in_item_i.request_bytes == 24'd0)) begin
            state_d = S_RESP;
          end else begin
            state_d = S_AWALK;
          end
        end
      end
      S_AWALK: begin
        if (fit) begin
          state_d = (!exact && tail_ok) ? S_ATAIL : S_RESP;
        end else if (!rdata_i.ln || k_max) begin
          state_d = S_RESP;
        end
      end
      S_ATAIL:  state_d = S_RESP;
      S_RCHK:   state_d = rel_ign ? S_RESP : S_RINS;
      S_RINS: begin
        if (!head_ok_q) begin
          state_d = S_RESP;
        end else if (ins_q < head_q) begin
          state_d = S_RHEAD;
        end else begin
          state_d = S_RWALK;
        end
      end
      S_RHEAD:  state_d = S_RESP;
      S_RWALK: begin
        if (!r_adv) begin
          state_d = S_RMERGE;
        end else if (k_max) begin
          state_d = S_RLAST;
        end
      end
      S_RLAST:  state_d = S_RMERGE;
      S_RMERGE: state_d = nb_merge ? S_RNB : S_RFIX;
      S_RNB:    state_d = S_RFIX;
      S_RFIX:   state_d = S_RESP;
      S_RESP:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
    if (cfg_i.restart) state_d = S_CLEAR;
  end

  always_comb begin
    clr_d       = clr_q;
    need_d      = need_q;
    addr_d      = addr_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    prev_sz_d   = prev_sz_q;
    k_d         = k_q;
    head_d      = head_q;
    head_ok_d   = head_ok_q;
    count_d     = count_q;
    ins_d       = ins_q;
    ins_hdr_d   = ins_hdr_q;
    cur_hdr_d   = cur_hdr_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    we_o        = 1'b0;
    waddr_o     = '0;
    wdata_o     = '0;
    raddr_o     = '0;
    unique case (state_q)
      S_CLEAR: begin
        we_o      = 1'b1;
        waddr_o   = clr_q;
        wdata_o   = (clr_q == '0) ? mk_hdr(1'b0, '0, SZ_W'(units)) : '0;
        head_d    = '0;
        head_ok_d = 1'b1;
        count_d   = CNT_W'(units);
        clr_d     = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          need_d  = need_in;
          addr_d  = in_item_i.release_address;
          stat_d  = (in_item_i.command == CMD_RELEASE) ? STAT_RELEASED : STAT_REFUSED;
          cur_d   = CUR_W'(head_q);
          prev_d  = head_q;
          k_d     = '0;
          raddr_o = head_q;
        end
      end
      S_AWALK: begin
        if (fit) begin
          stat_d  = STAT_ALLOC;
          count_d = count_q - need_q[CNT_W-1:0];
          if (exact) begin
            if (hit_head) begin
              head_ok_d = rdata_i.ln;
              head_d    = rdata_i.nx[IW-1:0];
            end else begin
              we_o    = 1'b1;
              waddr_o = prev_q;
              wdata_o = mk_hdr(rdata_i.ln, rdata_i.nx, prev_sz_q);
            end
          end else begin
            // shrink the extent and carve the request from its tail
            we_o    = 1'b1;
            waddr_o = cur_q[IW-1:0];
            wdata_o = mk_hdr(rdata_i.ln, rdata_i.nx, rest);
            cur_d   = tail;
            raddr_o = tail[IW-1:0];
          end
        end else if (rdata_i.ln && !k_max) begin
          prev_sz_d = rdata_i.sz;
          prev_d    = cur_q[IW-1:0];
          cur_d     = CUR_W'(rdata_i.nx);
          raddr_o   = rdata_i.nx[IW-1:0];
          k_d       = k_q + 1'b1;
        end
      end
      S_ATAIL: begin
        we_o    = 1'b1;
        waddr_o = cur_q[IW-1:0];
        wdata_o = mk_hdr(rdata_i.ln, rdata_i.nx, need_q[SZ_W-1:0]);
      end
      S_RCHK: begin
        if (rel_ign) begin
          stat_d = STAT_IGNORED;
        end else begin
          ins_d   = ins_w[IW-1:0];
          raddr_o = ins_w[IW-1:0];
        end
      end
      S_RINS: begin
        ins_hdr_d = rdata_i;
        count_d   = count_q + CNT_W'(rdata_i.sz);
        if (!head_ok_q) begin
          we_o      = 1'b1;
          waddr_o   = ins_q;
          wdata_o   = mk_hdr(1'b0, '0, rdata_i.sz);
          head_d    = ins_q;
          head_ok_d = 1'b1;
        end else begin
          raddr_o = head_q;
          cur_d   = CUR_W'(head_q);
          k_d     = '0;
        end
      end
      S_RHEAD: begin
        we_o    = 1'b1;
        waddr_o = ins_q;
        wdata_o = head_touch ? mk_hdr(rdata_i.ln, rdata_i.nx, ins_sz + rdata_i.sz)
                             : mk_hdr(1'b1, NXT_W'(head_q), ins_sz);
        head_d  = ins_q;
      end
      S_RWALK: begin
        if (r_adv) begin
          cur_d   = CUR_W'(rdata_i.nx);
          raddr_o = rdata_i.nx[IW-1:0];
          if (!k_max) k_d = k_q + 1'b1;
        end else begin
          cur_hdr_d = rdata_i;
        end
      end
      S_RLAST: cur_hdr_d = rdata_i;
      S_RMERGE: begin
        if (nb_merge) begin
          raddr_o = cur_hdr_q.nx[IW-1:0];
        end else begin
          we_o      = 1'b1;
          waddr_o   = ins_q;
          wdata_o   = mk_hdr(cur_hdr_q.ln, cur_hdr_q.nx, ins_sz);
          ins_hdr_d = mk_hdr(cur_hdr_q.ln, cur_hdr_q.nx, ins_sz);
        end
      end
      S_RNB: begin
        we_o      = 1'b1;
        waddr_o   = ins_q;
        wdata_o   = mk_hdr(rdata_i.ln, rdata_i.nx, ins_sz + rdata_i.sz);
        ins_hdr_d = mk_hdr(rdata_i.ln, rdata_i.nx, ins_sz + rdata_i.sz);
      end
      S_RFIX: begin
        we_o    = 1'b1;
        waddr_o = cur_q[IW-1:0];
        wdata_o = cur_touch ? mk_hdr(ins_hdr_q.ln, ins_hdr_q.nx, ce.sz + ins_hdr_q.sz)
                            : mk_hdr(1'b1, NXT_W'(ins_q), ce.sz);
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_item_d.status        = stat_q;
          out_item_d.block_address = (stat_q == STAT_ALLOC) ?
              cfg_i.heap_base + ((32'(cur_q) + 32'd1) << 4) : 32'd0;
          out_item_d.free_units    = count_q[12:0];
        end
      end
      default: ;
    endcase
    if (cfg_i.restart) clr_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      head_ok_q   <= 1'b1;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      head_ok_q   <= head_ok_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q     <= need_d;
    addr_q     <= addr_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    prev_sz_q  <= prev_sz_d;
    k_q        <= k_d;
    ins_q      <= ins_d;
    ins_hdr_q  <= ins_hdr_d;
    cur_hdr_q  <= cur_hdr_d;
    stat_q     <= stat_d;
    out_item_q <= out_item_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !cfg_i.restart |=> state_q != S_IDLE)
    else $error("accepted transfer did not start work");

  a_write_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> CUR_W'(waddr_o) < HU_C)
    else $error("header write beyond the store");

  a_head_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_ok_q && state_q == S_IDLE |-> CUR_W'(head_q) < HU_C)
    else $error("list head beyond the store");

  a_clear_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR && !cfg_i.restart && clr_q != C_LAST |=>
      state_q == S_CLEAR && clr_q == $past(clr_q) + 1'b1)
    else $error("clearing pass skipped an entry");

  a_result_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && state_q == S_RESP |=> state_q == S_RESP || cfg_i.restart)
    else $error("result dropped while output stalled");

endmodule

FILE: rtl/core/first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// First-fit heap allocator over 16-byte units with an address-ordered free list.
// ----------------------------------------------------------------------------
// Allocate walks the list, one header read per cycle from the header store, to the
// first fit; a split writes the tail header. Release checks the address, reads the
// freed header, makes it the only extent or the new head, or walks to its place and
// links or merges it with its neighbours. One item at a time; a waiting result does
// not block the next transfer. After reset and each HEAP_BASE or HEAP_BYTES write,
// a clearing pass writes all HEAP_UNITS headers, one a cycle, before items are taken.
module first_fit_free_list_allocator
  import ffa_pkg::*;
#(
  parameter int unsigned HEAP_UNITS = HEAP_UNITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int unsigned IW = $clog2(HEAP_UNITS);

  logic [31:0] heap_base_q, heap_base_d;
  logic [16:0] heap_bytes_q, heap_bytes_d;
  logic        restart;
  cfg_t        cfg;

  always_comb begin
    heap_base_d  = heap_base_q;
    heap_bytes_d = heap_bytes_q;
    restart      = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HEAP_BASE: begin
          heap_base_d = cfg_data_i;
          restart     = 1'b1;
        end
        REG_HEAP_BYTES: begin
          heap_bytes_d = cfg_data_i[16:0];
          restart      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= 32'd0;
      heap_bytes_q <= 17'h10000;
    end else begin
      heap_base_q  <= heap_base_d;
      heap_bytes_q <= heap_bytes_d;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign cfg.restart    = restart;
  assign cfg.heap_base  = heap_base_q;
  assign cfg.heap_bytes = heap_bytes_q;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  hdr_t          wdata, rdata;

  ffa_ctrl #(
    .HEAP_UNITS(HEAP_UNITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  ffa_hdr_mem #(
    .DEPTH(HEAP_UNITS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule
